FILE: rtl/optt_pkg.sv
// Shared constants and request codes for the one-shot/periodic tick timer.
`default_nettype none

package optt_pkg;

  localparam int unsigned DEF_COUNT_WIDTH = 32;
  localparam int unsigned DEF_STEP_WIDTH  = 16;

  localparam int unsigned DUR_W     = 32;  // period_length register
  localparam int unsigned STEP_IN_W = 16;  // step_amount field
  localparam int unsigned OUT_W     = 32;  // elapsed and remaining fields
  localparam int unsigned PCT_W     = 7;   // progress field and quotient bits
  localparam int unsigned ACC_W     = DUR_W + PCT_W;  // elapsed * 100 < 2^39

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_ADV   = 3'd1,
    REQ_START = 3'd2,
    REQ_STOP  = 3'd3,
    REQ_CLR   = 3'd4
  } req_e;

endpackage

`default_nettype wire

FILE: rtl/oneshot_periodic_tick_timer_core.sv
// Top level of the one-shot/periodic tick timer: sequencer, state and result register.
`default_nettype none

// Each request item (tick, advance by step, start, stop, clear) produces one status
// item. The timer and percentage arithmetic goes through one shared add/subtract unit under a small sequencer.
// A request steps through execute, status and done, with an expiry check between
// execute and status for a tick or a nonzero advance on a running timer. Whenever the
// elapsed count ends below the duration, for any request kind, the progress
// percentage adds a two-step multiply by 100 and a seven-step restoring divide. The
// input is not ready while an item is in work. A finished status waits in the output
// register while the next request is taken; that request then holds in its last step
// until the register frees. The duration register is written by cfg_we_i with no
// handshake.
module oneshot_periodic_tick_timer_core
  import optt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int unsigned STEP_WIDTH  = DEF_STEP_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [DUR_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [2:0]           req_type_i,
  input  wire logic [STEP_IN_W-1:0] step_amount_i,
  input  wire logic                 start_repeating_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      fired_o,
  output logic                      is_running_o,
  output logic                      is_expired_o,
  output logic [OUT_W-1:0]          elapsed_count_o,
  output logic [OUT_W-1:0]          remaining_count_o,
  output logic [PCT_W-1:0]          progress_percent_o
);

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned SW     = (STEP_WIDTH < STEP_IN_W) ? STEP_WIDTH : STEP_IN_W;
  localparam int unsigned AW     = ((CW > ACC_W) ? CW : ACC_W) + 1;
  localparam int unsigned CNT_W  = $clog2(PCT_W);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_EXP  = 8'b0000_0100,
    S_STAT = 8'b0000_1000,
    S_MUL1 = 8'b0001_0000,
    S_MUL2 = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [SW-1:0]     step_q, step_d;
  logic              rep_q, rep_d;
  logic [CW-1:0]     elapsed_q, elapsed_d;
  logic              run_q, run_d;
  logic              repeat_q, repeat_d;
  logic [DUR_W-1:0]  period_q;
  logic              fired_q, fired_d;
  logic              expired_q, expired_d;
  logic [OUT_W-1:0]  remain_q, remain_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [PCT_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic              fired_out_q, running_out_q, expired_out_q;
  logic [OUT_W-1:0]  elapsed_out_q, remain_out_q;
  logic [PCT_W-1:0]  pct_out_q;

  logic [AW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_sub, alu_co;
  logic [AW-1:0]     elapsed_x, dur_x, acc_x, lo_x, step_x;
  logic              accept, load_out, lt;

  assign elapsed_x = {{(AW-CW){1'b0}}, elapsed_q};
  assign dur_x     = {{(AW-DUR_W){1'b0}}, period_q};
  assign acc_x     = {{(AW-ACC_W){1'b0}}, acc_q};
  assign lo_x      = {{(AW-DUR_W){1'b0}}, elapsed_x[DUR_W-1:0]};
  assign step_x    = {{(AW-SW){1'b0}}, step_q};

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign lt         = alu_co && (alu_res != '0);

  optt_alu #(
    .Width(AW)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .carry_o(alu_co)
  );

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_EXEC: begin
        alu_a = elapsed_x;
        alu_b = (req_q == REQ_TICK) ? AW'(1) : step_x;
      end
      S_EXP: begin
        alu_a   = elapsed_x;
        alu_b   = dur_x;
        alu_sub = 1'b1;
      end
      S_STAT: begin
        alu_a   = dur_x;
        alu_b   = elapsed_x;
        alu_sub = 1'b1;
      end
      S_MUL1: begin
        alu_a = lo_x << 6;
        alu_b = lo_x << 5;
      end
      S_MUL2: begin
        alu_a = acc_x;
        alu_b = lo_x << 2;
      end
      S_DIV: begin
        alu_a   = acc_x;
        alu_b   = dur_x << cnt_q;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    step_d    = step_q;
    rep_d     = rep_q;
    elapsed_d = elapsed_q;
    run_d     = run_q;
    repeat_d  = repeat_q;
    fired_d   = fired_q;
    expired_d = expired_q;
    remain_d  = remain_q;
    acc_d     = acc_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_e'(req_type_i);
          step_d  = step_amount_i[SW-1:0];
          rep_d   = start_repeating_i;
          fired_d = 1'b0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_STAT;
        unique case (req_q) inside
          REQ_TICK, REQ_ADV: begin
            if (run_q && (req_q == REQ_TICK || step_q != '0)) begin
              // Saturate at the top of the count.
              elapsed_d = (alu_res[AW-1:CW] != '0) ? '1 : alu_res[CW-1:0];
              state_d   = S_EXP;
            end
          end
          REQ_START: begin
            if (period_q != '0) begin
              elapsed_d = '0;
              run_d     = 1'b1;
              repeat_d  = rep_q;
            end
          end
          REQ_STOP: run_d = 1'b0;
          REQ_CLR:  elapsed_d = '0;
          default: begin
          end
        endcase
      end
      S_EXP: begin
        if (alu_co) begin
          fired_d = 1'b1;
          if (req_q == REQ_TICK) begin
            if (repeat_q) elapsed_d = '0;
            else          run_d = 1'b0;
          end else if (repeat_q) begin
            elapsed_d = alu_res[CW-1:0];  // keep the overshoot
          end else begin
            elapsed_d = dur_x[CW-1:0];
            run_d     = 1'b0;
          end
        end
        state_d = S_STAT;
      end
      S_STAT: begin
        expired_d = !run_q && !lt;
        remain_d  = lt ? alu_res[OUT_W-1:0] : '0;
        if (lt) begin
          quo_d   = '0;
          cnt_d   = CNT_W'(PCT_W - 1);
          state_d = S_MUL1;
        end else begin
          quo_d   = (period_q != '0) ? PCT_FULL : '0;
          state_d = S_DONE;
        end
      end
      S_MUL1: begin
        acc_d   = alu_res[ACC_W-1:0];
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = alu_res[ACC_W-1:0];
        state_d = S_DIV;
      end
      S_DIV: begin
        if (alu_co) begin
          acc_d        = alu_res[ACC_W-1:0];
          quo_d[cnt_q] = 1'b1;
        end
        if (cnt_q == '0) state_d = S_DONE;
        else             cnt_d = cnt_q - 1'b1;
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      elapsed_q   <= '0;
      run_q       <= 1'b0;
      repeat_q    <= 1'b0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      run_q       <= run_d;
      repeat_q    <= repeat_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    step_q    <= step_d;
    rep_q     <= rep_d;
    fired_q   <= fired_d;
    expired_q <= expired_d;
    remain_q  <= remain_d;
    acc_q     <= acc_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    if (load_out) begin
      fired_out_q   <= fired_q;
      running_out_q <= run_q;
      expired_out_q <= expired_q;
      elapsed_out_q <= elapsed_x[OUT_W-1:0];
      remain_out_q  <= remain_q;
      pct_out_q     <= quo_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign fired_o            = fired_out_q;
  assign is_running_o       = running_out_q;
  assign is_expired_o       = expired_out_q;
  assign elapsed_count_o    = elapsed_out_q;
  assign remaining_count_o  = remain_out_q;
  assign progress_percent_o = pct_out_q;

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> progress_percent_o <= PCT_FULL)
    else $error("progress above 100 percent");

  a_expired_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_expired_o |-> !is_running_o)
    else $error("expired while running");

  a_fired_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> is_running_o || is_expired_o)
    else $error("fired but neither restarted nor expired");

  a_remain_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && remaining_count_o == '0 |->
      progress_percent_o == PCT_FULL || progress_percent_o == '0)
    else $error("no time remaining but progress partial");
`endif

endmodule

`default_nettype wire

FILE: rtl/optt_alu.sv
// Shared add/subtract unit with carry out, reused by every arithmetic step of the sequencer.
`default_nettype none

module optt_alu #(
  parameter int unsigned Width = 40
) (
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  input  wire logic             sub_i,
  output logic      [Width-1:0] res_o,
  output logic                  carry_o
);

  logic [Width-1:0] b_op;
  logic [Width:0]   sum;

  // Subtract as a + ~b + 1; carry out set means a >= b.
  assign b_op = sub_i ? ~b_i : b_i;
  assign sum  = {1'b0, a_i} + {1'b0, b_op} + {{Width{1'b0}}, sub_i};

  assign res_o   = sum[Width-1:0];
  assign carry_o = sum[Width];

endmodule

`default_nettype wire
